FILE: design/sem_pkg.sv
// Shared constants, codes and word types of the Sobel edge magnitude block.
`timescale 1ns / 1ps

package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int LS_AW      = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 8;
    localparam int LS_DW      = 2 * PIX_W;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 16;
    localparam int ROW_W      = HGT_W + 1;
    localparam int EMIT_W     = 26;
    localparam int AREA_W     = WID_W + HGT_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = HGT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [WID_W-1:0]  RESET_WIDTH  = 11'd640;
    localparam logic [HGT_W-1:0]  RESET_HEIGHT = 16'd480;
    localparam logic [AREA_W-1:0] RESET_AREA   = AREA_W'(640 * 480);

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef struct packed {
        logic [PIX_W-1:0] edge_strength;
        logic             frame_last;
    } edge_word_t;

    typedef struct packed {
        logic [LS_AW-1:0] rd_addr;
        logic             wr_en;
        logic [LS_AW-1:0] wr_addr;
        logic [LS_DW-1:0] wr_data;
    } ls_req_t;

endpackage

FILE: design/sem_pixel_if.sv
// Pixel input channel: valid/ready handshake carrying one RGB word.
`timescale 1ns / 1ps

interface sem_pixel_if
    import sem_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             drain;

    modport source (output valid, output red, output green, output blue, output drain,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input drain,
                    output ready);
endinterface

FILE: design/sem_edge_if.sv
// Result channel: valid/ready handshake carrying one edge strength word.
`timescale 1ns / 1ps

interface sem_edge_if
    import sem_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] edge_strength;
    logic             frame_last;

    modport source (output valid, output edge_strength, output frame_last, input ready);
    modport sink   (input valid, input edge_strength, input frame_last, output ready);
endinterface

FILE: design/sobel_edge_magnitude_top.sv
// Top level of the streaming 3x3 Sobel edge magnitude filter.
//
//  channel   dir  handshake      word
//  pixels    in   valid/ready    red, green, blue (8 b each), drain (1 b)
//  results   out  valid/ready    edge_strength (8 b), frame_last (1 b)
//  cfg       in   cfg_we only    cfg_index (0 width, 1 height), cfg_data (16 b)
//
// One pixel word per clock while the result queue has room. A word runs through
// three stages: position and gray on acceptance (line store read issued), window
// update and line store write-back, then the gradient into a four-word result
// queue, from which the result channel is served.
// After reset the line stores are cleared, one entry a cycle: pixels.ready stays
// low until all MAX_WIDTH (1024) entries are clear. A config write holds ready low
// in the cycle after it while the frame area is recomputed.
// A stalled result channel stops intake only once the queue plus the words in
// flight would fill it; the pipeline itself never stalls.
`timescale 1ns / 1ps

module sobel_edge_magnitude_top
    import sem_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sem_pixel_if.sink             pixels,
    sem_edge_if.source            results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [WID_W-1:0]  frame_width_reg;
    logic [HGT_W-1:0]  frame_height_reg;
    logic [AREA_W-1:0] area_reg;
    logic              cfg_hold_reg;
    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;

    // frame position
    logic [LS_AW-1:0]  col_reg;
    logic [LS_AW-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [EMIT_W-1:0] emitted_reg;
    logic [EMIT_W-1:0] emitted_next;

    // acceptance stage
    logic              accept;
    logic              wrap_start;
    logic [LS_AW-1:0]  col_a;
    logic [ROW_W-1:0]  row_a;
    logic              primed;
    logic [WID_W-1:0]  cx;
    logic [ROW_W-1:0]  cy;
    logic              border_a;
    logic              last_a;
    logic [WID_W-1:0]  col_inc;
    logic [12:0]       gray_sum;
    logic [PIX_W-1:0]  gray_a;

    // write-back stage
    logic              vb_reg;
    logic [LS_AW-1:0]  col_b_reg;
    logic [PIX_W-1:0]  gray_b_reg;
    logic              emit_b_reg;
    logic              last_b_reg;
    logic              border_b_reg;
    logic [LS_DW-1:0]  ls_rd_data;
    logic              ls_busy;
    ls_req_t           ls_req;
    logic [PIX_W-1:0]  upper_new;
    logic [PIX_W-1:0]  middle_new;

    // gradient stage
    logic [PIX_W-1:0]  win_reg [9];
    logic              vc_reg;
    logic              emit_c_reg;
    logic              last_c_reg;
    logic              border_c_reg;
    logic [9:0]        sum_right;
    logic [9:0]        sum_left;
    logic [9:0]        sum_bottom;
    logic [9:0]        sum_top;
    logic [10:0]       gx;
    logic [10:0]       gy;
    logic [10:0]       abs_x;
    logic [10:0]       abs_y;
    logic [10:0]       mag;
    logic [PIX_W-1:0]  mag_sat;
    logic              push;
    edge_word_t        push_word;
    logic [FIFO_CW-1:0] fifo_count;
    logic [FIFO_CW-1:0] pending;

    // ---------------- configuration ----------------
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (frame_width_reg > WID_W'(MAX_WIDTH))
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = frame_width_reg;
        end
        h_eff = (frame_height_reg == '0) ? HGT_W'(1) : frame_height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_WIDTH;
            frame_height_reg <= RESET_HEIGHT;
            area_reg         <= RESET_AREA;
            cfg_hold_reg     <= 1'b0;
        end
        else
        begin
            cfg_hold_reg <= cfg_we;
            area_reg     <= AREA_W'(w_eff) * AREA_W'(h_eff);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[WID_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[HGT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- acceptance: position, flags, gray ----------------
    // Room is reserved in the result queue for every word still in flight.
    assign pending      = fifo_count + FIFO_CW'(vb_reg) + FIFO_CW'(vc_reg);
    assign pixels.ready = !ls_busy && !cfg_hold_reg && (pending < FIFO_CW'(FIFO_DEPTH));
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        // a column left beyond a narrowed width wraps to the next line first
        wrap_start = WID_W'(col_reg) >= w_eff;
        col_a      = wrap_start ? '0 : col_reg;
        row_a      = wrap_start ? row_reg + 1'b1 : row_reg;

        // the window centre trails the input by one line plus one pixel
        primed = (row_a >= ROW_W'(2)) || ((row_a == ROW_W'(1)) && (col_a != '0));
        cx     = (col_a == '0) ? w_eff - 1'b1 : WID_W'(col_a) - 1'b1;
        cy     = (col_a == '0) ? row_a - ROW_W'(2) : row_a - ROW_W'(1);

        border_a = (cx == '0)
                || (({1'b0, cx} + 1'b1) >= {1'b0, w_eff})
                || (cy == '0)
                || (({1'b0, cy} + 1'b1) >= {2'b00, h_eff});
        last_a   = ({1'b0, emitted_reg} + 1'b1) >= area_reg;

        col_inc = WID_W'(col_a) + 1'b1;

        if (primed && last_a)
        begin
            col_next     = '0;
            row_next     = '0;
            emitted_next = '0;
        end
        else
        begin
            emitted_next = primed ? emitted_reg + 1'b1 : emitted_reg;
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = row_a + 1'b1;
            end
            else
            begin
                col_next = col_inc[LS_AW-1:0];
                row_next = row_a;
            end
        end

        gray_sum = 13'(pixels.red) * 13'd11 + 13'(pixels.green) * 13'd16
                 + 13'(pixels.blue) * 13'd5;
        gray_a   = pixels.drain ? '0 : gray_sum[12:5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            emitted_reg <= '0;
            vb_reg      <= 1'b0;
        end
        else
        begin
            vb_reg <= accept;
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                emitted_reg <= emitted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_b_reg    <= col_a;
            gray_b_reg   <= gray_a;
            emit_b_reg   <= primed;
            last_b_reg   <= last_a;
            border_b_reg <= border_a;
        end
    end

    // ---------------- line stores: read on acceptance, write back next cycle ----
    assign upper_new  = ls_rd_data[LS_DW-1:PIX_W];
    assign middle_new = ls_rd_data[PIX_W-1:0];

    always_comb
    begin
        ls_req.rd_addr = col_a;
        ls_req.wr_en   = vb_reg;
        ls_req.wr_addr = col_b_reg;
        ls_req.wr_data = {middle_new, gray_b_reg};   // middle moves up, gray enters
    end

    sem_line_store u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ls_req),
        .rd_data (ls_rd_data),
        .busy    (ls_busy)
    );

    // window rows top to bottom, columns left to right: win_reg[row*3 + col]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            vc_reg <= 1'b0;
        end
        else
        begin
            vc_reg <= vb_reg;
            if (vb_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]     <= win_reg[r*3 + 1];
                    win_reg[r*3 + 1] <= win_reg[r*3 + 2];
                end
                win_reg[2] <= upper_new;
                win_reg[5] <= middle_new;
                win_reg[8] <= gray_b_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vb_reg)
        begin
            emit_c_reg   <= emit_b_reg;
            last_c_reg   <= last_b_reg;
            border_c_reg <= border_b_reg;
        end
    end

    // ---------------- gradient ----------------
    always_comb
    begin
        sum_right  = 10'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + 10'(win_reg[8]);
        sum_left   = 10'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + 10'(win_reg[6]);
        sum_bottom = 10'(win_reg[6]) + {1'b0, win_reg[7], 1'b0} + 10'(win_reg[8]);
        sum_top    = 10'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + 10'(win_reg[2]);
        gx         = {1'b0, sum_right} - {1'b0, sum_left};
        gy         = {1'b0, sum_bottom} - {1'b0, sum_top};
        abs_x      = gx[10] ? -gx : gx;
        abs_y      = gy[10] ? -gy : gy;
        mag        = abs_x + abs_y;
        mag_sat    = (mag > 11'(PIX_MAX)) ? PIX_MAX : mag[PIX_W-1:0];

        push                    = vc_reg && emit_c_reg;
        push_word.edge_strength = border_c_reg ? '0 : mag_sat;
        push_word.frame_last    = last_c_reg;
    end

    sem_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .count     (fifo_count),
        .results   (results)
    );

endmodule

FILE: design/sem_line_store.sv
// Paired line store {upper, middle}: registered read, write forwarding, clear after reset.
`timescale 1ns / 1ps

module sem_line_store
    import sem_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ls_req_t          req,
    output logic [LS_DW-1:0] rd_data,
    output logic             busy
);

    logic [LS_DW-1:0] mem [MAX_WIDTH];
    logic [LS_DW-1:0] rd_data_reg;
    logic [LS_AW:0]   clr_cnt_reg;
    logic [LS_AW:0]   clr_cnt_next;

    assign busy    = clr_cnt_reg < (LS_AW + 1)'(MAX_WIDTH);
    assign rd_data = rd_data_reg;

    always_comb
    begin
        clr_cnt_next = busy ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // read-before-write array; a write to the address being read is forwarded
    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            mem[clr_cnt_reg[LS_AW-1:0]] <= '0;
        end
        else if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.wr_en && (req.wr_addr == req.rd_addr))
        begin
            rd_data_reg <= req.wr_data;
        end
        else
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

endmodule

FILE: design/sem_out_fifo.sv
// Small result queue that decouples the filter pipeline from the result channel.
`timescale 1ns / 1ps

module sem_out_fifo
    import sem_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  edge_word_t         push_word,
    output logic [FIFO_CW-1:0] count,
    sem_edge_if.source         results
);

    edge_word_t           entries_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   head_reg;
    logic [FIFO_AW-1:0]   head_next;
    logic [FIFO_AW-1:0]   tail_reg;
    logic [FIFO_AW-1:0]   tail_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    logic                 pop;
    edge_word_t           head_word;

    assign head_word             = entries_reg[head_reg];
    assign results.valid         = count_reg != '0;
    assign results.edge_strength = head_word.edge_strength;
    assign results.frame_last    = head_word.frame_last;
    assign pop                   = results.valid && results.ready;
    assign count                 = count_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = (head_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[tail_reg] <= push_word;
        end
    end

endmodule

FILE: design/sem_checker.sv
// Port-level checks of the Sobel edge magnitude top, attached by bind.
`timescale 1ns / 1ps

module sem_checker
    import sem_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PIX_W-1:0] out_edge_strength,
    input logic             out_frame_last,
    input logic             cfg_we
);

    // a waiting result word keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_edge_strength)
                                    && $stable(out_frame_last))
        else $error("result word changed while stalled");

    // an empty queue refills only from an accepted pixel that has passed the write-back and gradient stages
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 3))
        else $error("result appeared without a matching pixel");

    // the line store clear holds intake off as reset lifts
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("pixel taken before line stores cleared");

    // the frame area settles in the cycle after a register write
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("pixel taken straight after config write");

endmodule

bind sobel_edge_magnitude_top sem_checker u_sem_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (pixels.valid),
    .in_ready          (pixels.ready),
    .out_valid         (results.valid),
    .out_ready         (results.ready),
    .out_edge_strength (results.edge_strength),
    .out_frame_last    (results.frame_last),
    .cfg_we            (cfg_we)
);
